@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the checker files of this block.
// Depends on nothing; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define BFAQM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("bloom filter check failed");

// Condition that must never be seen outside reset.
`define BFAQM_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("bloom filter forbidden condition seen");

`endif

@@ rtl/core/bfaqm_pkg.sv @@
// Package for the Bloom filter: sizes, hash constants, codes and helpers.
// Used by the top level, the multiplier and the checker; depends on nothing.
package bfaqm_pkg;

    localparam int LOG_BITS_MAX = 16;
    localparam int HASH_COUNT   = 7;
    localparam int ADDR_W       = LOG_BITS_MAX - 3;
    localparam int STORE_DEPTH  = 1 << ADDR_W;
    localparam int LANE_W       = (HASH_COUNT > 1) ? $clog2(HASH_COUNT) : 1;
    localparam int LOG_W        = 5;

    localparam logic [31:0] MM_C1    = 32'hcc9e2d51;
    localparam logic [31:0] MM_C2    = 32'h1b873593;
    localparam logic [31:0] MM_F1    = 32'h85ebca6b;
    localparam logic [31:0] MM_F2    = 32'hc2b2ae35;
    localparam logic [31:0] LANE_ADD = 32'he6546b64;

    localparam logic [LOG_W-1:0] LOG_BITS_MIN   = 5'd3;
    localparam logic [LOG_W-1:0] LOG_BITS_TOP   = LOG_W'(LOG_BITS_MAX);
    localparam logic [LOG_W-1:0] LOG_BITS_RESET = 5'd16;

    // Request function codes.
    typedef enum logic [1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_QUERY = 2'd1,
        FUNC_MERGE = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    // Constant chosen for the shared multiplier.
    typedef enum logic [1:0] {
        MUL_C1 = 2'd0,
        MUL_C2 = 2'd1,
        MUL_F1 = 2'd2,
        MUL_F2 = 2'd3
    } mul_sel_t;

    typedef struct packed {
        logic     en;
        mul_sel_t sel;
    } mul_ctrl_t;

    function automatic logic [31:0] rotl15(input logic [31:0] x);
        return {x[16:0], x[31:17]};
    endfunction

    function automatic logic [31:0] rotl13(input logic [31:0] x);
        return {x[18:0], x[31:19]};
    endfunction

endpackage

@@ rtl/core/bfaqm_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read.
// Depends on nothing.
module bfaqm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/bfaqm_mul.sv @@
// Shared 32-bit multiplier by one of the MurmurHash3 constants, registered.
// Depends on bfaqm_pkg.
module bfaqm_mul (
    input  logic                  clk,
    input  bfaqm_pkg::mul_ctrl_t  ctrl,
    input  logic [31:0]           a,
    output logic [31:0]           prod_reg
);

    logic [31:0] coef;

    // Select the constant for this step.
    always_comb
    begin
        unique case (ctrl.sel)
            bfaqm_pkg::MUL_C1: coef = bfaqm_pkg::MM_C1;
            bfaqm_pkg::MUL_C2: coef = bfaqm_pkg::MM_C2;
            bfaqm_pkg::MUL_F1: coef = bfaqm_pkg::MM_F1;
            bfaqm_pkg::MUL_F2: coef = bfaqm_pkg::MM_F2;
            default:           coef = bfaqm_pkg::MM_C1;
        endcase
    end

    // The product holds until the next enabled step.
    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            prod_reg <= a * coef;
        end
    end

endmodule

@@ rtl/core/bloom_filter_add_query_merge.sv @@
// Top level of the Bloom filter: request sequencer, hash lanes and store.
// Depends on bfaqm_pkg, bfaqm_ram and bfaqm_mul.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-----------------------------------------
//  request   | start / busy       | func, data_byte, last_byte, merge_address
//  result    | result_valid       | member
//  config    | cfg_we             | cfg_wdata
//
// A key byte that does not complete a 4-byte block is taken in the idle state;
// one that completes a block takes the request cycle and one more multiplier
// step, then one lane a cycle. A last byte adds the tail states when the key
// length is not a multiple of 4, then per lane two multiplies, a store read
// and a store write. Merge ORs data_byte into the store byte at merge_address.
// After reset the store is cleared one byte a cycle, with busy high. The result
// strobe lasts one cycle and cannot be stalled.
module bloom_filter_add_query_merge (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     func,
    input  logic [7:0]                     data_byte,
    input  logic                           last_byte,
    input  logic [12:0]                    merge_address,
    output logic                           result_valid,
    output logic                           member,
    input  logic                           cfg_we,
    input  logic [bfaqm_pkg::LOG_W-1:0]    cfg_wdata
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MERGE,
        ST_BLK_M2,
        ST_LANE,
        ST_FIN_START,
        ST_TAIL_M2,
        ST_TAIL_K,
        ST_FIN_A,
        ST_FIN_B,
        ST_FIN_C,
        ST_FIN_D
    } state_t;

    state_t                               state_reg;
    logic [bfaqm_pkg::ADDR_W-1:0]         clr_cnt_reg;
    logic [31:0]                          lane_reg [bfaqm_pkg::HASH_COUNT];
    logic [bfaqm_pkg::LANE_W-1:0]         lane_idx_reg;
    logic [23:0]                          block_reg;
    logic [31:0]                          len_reg;
    logic                                 last_reg;
    bfaqm_pkg::func_t                     func_reg;
    logic [31:0]                          tail_reg;
    logic [bfaqm_pkg::ADDR_W-1:0]         addr_reg;
    logic [7:0]                           byte_reg;
    logic                                 all_set_reg;
    logic [bfaqm_pkg::LOG_W-1:0]          log_bits_reg;
    logic                                 result_valid_reg;
    logic                                 member_reg;

    bfaqm_pkg::mul_ctrl_t                 mul_ctrl;
    logic [31:0]                          mul_a;
    logic [31:0]                          prod;
    logic                                 ram_we;
    logic [bfaqm_pkg::ADDR_W-1:0]         ram_waddr;
    logic [7:0]                           ram_wdata;
    logic [bfaqm_pkg::ADDR_W-1:0]         ram_raddr;
    logic [7:0]                           ram_rdata;

    logic                                 accept;
    bfaqm_pkg::func_t                     func_in;
    logic [1:0]                           pos;
    logic [31:0]                          cur_lane;
    logic [31:0]                          lane_mix;
    logic [31:0]                          lane_next;
    logic [31:0]                          fin_x;
    logic [31:0]                          fin_h1;
    logic [31:0]                          fin_h2;
    logic [31:0]                          fin_h3;
    logic [bfaqm_pkg::LOG_W-1:0]          n_eff;
    logic [5:0]                           shift_amt;
    logic [31:0]                          idx_full;
    logic [bfaqm_pkg::LOG_BITS_MAX-1:0]   idx;
    logic [7:0]                           bit_mask_reg;
    logic [7:0]                           bit_mask;
    logic                                 last_lane;
    logic                                 tail_needed;

    assign accept       = start && !busy;
    assign func_in      = bfaqm_pkg::func_t'(func);
    assign pos          = len_reg[1:0];
    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign member       = member_reg;
    assign last_lane    = (lane_idx_reg == bfaqm_pkg::LANE_W'(bfaqm_pkg::HASH_COUNT - 1));
    assign tail_needed  = (len_reg[1:0] != 2'd0);

    // Clamp the configured filter size to the supported range.
    always_comb
    begin
        priority if (log_bits_reg < bfaqm_pkg::LOG_BITS_MIN)
        begin
            n_eff = bfaqm_pkg::LOG_BITS_MIN;
        end
        else if (log_bits_reg > bfaqm_pkg::LOG_BITS_TOP)
        begin
            n_eff = bfaqm_pkg::LOG_BITS_TOP;
        end
        else
        begin
            n_eff = log_bits_reg;
        end
    end

    // Lane datapath: block mixing and finalisation for the selected lane.
    always_comb
    begin
        cur_lane  = lane_reg[lane_idx_reg];
        lane_mix  = bfaqm_pkg::rotl13(cur_lane ^ prod);
        lane_next = lane_mix + {lane_mix[29:0], 2'b00} + bfaqm_pkg::LANE_ADD;
        fin_x     = cur_lane ^ tail_reg ^ len_reg;
        fin_h1    = fin_x ^ {16'd0, fin_x[31:16]};
        fin_h2    = prod ^ {13'd0, prod[31:13]};
        fin_h3    = prod ^ {16'd0, prod[31:16]};
        shift_amt = 6'd32 - {1'b0, n_eff};
        idx_full  = fin_h3 >> shift_amt;
        idx       = idx_full[bfaqm_pkg::LOG_BITS_MAX-1:0];
        bit_mask  = 8'h80 >> idx[2:0];
    end

    // Multiplier operand and constant for each step.
    always_comb
    begin
        mul_ctrl.en  = 1'b0;
        mul_ctrl.sel = bfaqm_pkg::MUL_C1;
        mul_a        = {data_byte, block_reg};
        unique case (state_reg)
            ST_IDLE:
            begin
                mul_ctrl.en = accept && pos == 2'd3
                              && (func_in == bfaqm_pkg::FUNC_ADD
                                  || func_in == bfaqm_pkg::FUNC_QUERY);
            end
            ST_BLK_M2, ST_TAIL_M2:
            begin
                mul_ctrl.en  = 1'b1;
                mul_ctrl.sel = bfaqm_pkg::MUL_C2;
                mul_a        = bfaqm_pkg::rotl15(prod);
            end
            ST_FIN_START:
            begin
                mul_ctrl.en = tail_needed;
                mul_a       = {8'd0, block_reg};
            end
            ST_FIN_A:
            begin
                mul_ctrl.en  = 1'b1;
                mul_ctrl.sel = bfaqm_pkg::MUL_F1;
                mul_a        = fin_h1;
            end
            ST_FIN_B:
            begin
                mul_ctrl.en  = 1'b1;
                mul_ctrl.sel = bfaqm_pkg::MUL_F2;
                mul_a        = fin_h2;
            end
            default:
            begin
                mul_ctrl.en = 1'b0;
            end
        endcase
    end

    // Store access: clearing pass, merge and bit update.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = ram_rdata | byte_reg;
        ram_raddr = merge_address;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = 8'd0;
            end
            ST_MERGE:
            begin
                ram_we = 1'b1;
            end
            ST_FIN_C:
            begin
                ram_raddr = idx[bfaqm_pkg::LOG_BITS_MAX-1:3];
            end
            ST_FIN_D:
            begin
                ram_we    = (func_reg == bfaqm_pkg::FUNC_ADD);
                ram_wdata = ram_rdata | bit_mask_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Sequencer with key state and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            for (int i = 0; i < bfaqm_pkg::HASH_COUNT; i++)
            begin
                lane_reg[i] <= 32'(i);
            end
            lane_idx_reg     <= '0;
            block_reg        <= '0;
            len_reg          <= '0;
            last_reg         <= 1'b0;
            func_reg         <= bfaqm_pkg::FUNC_ADD;
            tail_reg         <= '0;
            addr_reg         <= '0;
            byte_reg         <= '0;
            bit_mask_reg     <= '0;
            all_set_reg      <= 1'b1;
            log_bits_reg     <= bfaqm_pkg::LOG_BITS_RESET;
            result_valid_reg <= 1'b0;
            member_reg       <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                log_bits_reg <= cfg_wdata;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == bfaqm_pkg::ADDR_W'(bfaqm_pkg::STORE_DEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        last_reg     <= last_byte;
                        func_reg     <= func_in;
                        addr_reg     <= merge_address;
                        byte_reg     <= data_byte;
                        lane_idx_reg <= '0;
                        all_set_reg  <= 1'b1;
                        unique case (func_in)
                            bfaqm_pkg::FUNC_MERGE:
                            begin
                                state_reg <= ST_MERGE;
                            end
                            bfaqm_pkg::FUNC_ADD, bfaqm_pkg::FUNC_QUERY:
                            begin
                                len_reg <= len_reg + 32'd1;
                                if (pos == 2'd3)
                                begin
                                    block_reg <= '0;
                                    state_reg <= ST_BLK_M2;
                                end
                                else
                                begin
                                    block_reg <= block_reg
                                                 | (24'(data_byte) << {pos, 3'b000});
                                    if (last_byte)
                                    begin
                                        state_reg <= ST_FIN_START;
                                    end
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_MERGE:
                begin
                    state_reg <= ST_IDLE;
                end
                ST_BLK_M2:
                begin
                    state_reg <= ST_LANE;
                end
                ST_LANE:
                begin
                    lane_reg[lane_idx_reg] <= lane_next;
                    if (last_lane)
                    begin
                        lane_idx_reg <= '0;
                        state_reg    <= last_reg ? ST_FIN_START : ST_IDLE;
                    end
                    else
                    begin
                        lane_idx_reg <= lane_idx_reg + 1'b1;
                    end
                end
                ST_FIN_START:
                begin
                    tail_reg  <= '0;
                    state_reg <= tail_needed ? ST_TAIL_M2 : ST_FIN_A;
                end
                ST_TAIL_M2:
                begin
                    state_reg <= ST_TAIL_K;
                end
                ST_TAIL_K:
                begin
                    tail_reg  <= prod;
                    state_reg <= ST_FIN_A;
                end
                ST_FIN_A:
                begin
                    state_reg <= ST_FIN_B;
                end
                ST_FIN_B:
                begin
                    state_reg <= ST_FIN_C;
                end
                ST_FIN_C:
                begin
                    addr_reg     <= idx[bfaqm_pkg::LOG_BITS_MAX-1:3];
                    bit_mask_reg <= bit_mask;
                    state_reg    <= ST_FIN_D;
                end
                ST_FIN_D:
                begin
                    // Test the bit for a query; the write itself is combinational.
                    if ((ram_rdata & bit_mask_reg) == 8'd0)
                    begin
                        all_set_reg <= 1'b0;
                    end
                    if (last_lane)
                    begin
                        for (int i = 0; i < bfaqm_pkg::HASH_COUNT; i++)
                        begin
                            lane_reg[i] <= 32'(i);
                        end
                        lane_idx_reg <= '0;
                        block_reg    <= '0;
                        len_reg      <= '0;
                        state_reg    <= ST_IDLE;
                        if (func_reg == bfaqm_pkg::FUNC_QUERY)
                        begin
                            result_valid_reg <= 1'b1;
                            member_reg       <= all_set_reg
                                                && ((ram_rdata & bit_mask_reg) != 8'd0);
                        end
                    end
                    else
                    begin
                        lane_idx_reg <= lane_idx_reg + 1'b1;
                        state_reg    <= ST_FIN_A;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Filter store.
    bfaqm_ram #(
        .WIDTH (8),
        .DEPTH (bfaqm_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared multiplier for scrambling and finalisation.
    bfaqm_mul u_mul (
        .clk      (clk),
        .ctrl     (mul_ctrl),
        .a        (mul_a),
        .prod_reg (prod)
    );

endmodule

@@ rtl/core/bfaqm_checker.sv @@
// Port-level checks for the Bloom filter, bound to the top level.
// Depends on assert_macros.svh and bfaqm_pkg.
`include "assert_macros.svh"

module bfaqm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] func,
    input logic       last_byte,
    input logic       result_valid
);

    // A result appears only once the block has gone back to idle.
    `BFAQM_ASSERT(a_result_idle, clk, rst_n, result_valid |-> !busy)

    // Results are never issued on consecutive cycles.
    `BFAQM_ASSERT(a_result_single, clk, rst_n, result_valid |=> !result_valid)

    // No result follows directly after a request is taken.
    `BFAQM_ASSERT(a_no_instant_result, clk, rst_n, (start && !busy) |=> !result_valid)

    // The last byte of a query keeps the block busy while the lanes finish.
    `BFAQM_ASSERT(a_query_busy, clk, rst_n,
        (start && !busy && last_byte && func == bfaqm_pkg::FUNC_QUERY) |=> busy)

endmodule

bind bloom_filter_add_query_merge bfaqm_checker u_bfaqm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .last_byte    (last_byte),
    .result_valid (result_valid)
);
